[rtl/dsrbh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsrbh_pkg
// Shared types, constants and helpers of the dual-sum rotating block hash.
// ----------------------------------------------------------------------------
package dsrbh_pkg;

    localparam int unsigned HASH_W       = 32;
    localparam int unsigned LEN_W        = 16;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned PARTIAL_W    = 24;

    // Blocks with at least this many bytes left close a group of four words
    localparam logic [LEN_W-1:0] GROUP_MIN_BYTES = 16'd16;
    // Fewer than a word left: trailing bytes go in one at a time
    localparam logic [LEN_W-1:0] WORD_BYTES      = 16'd4;
    localparam logic [1:0]       LAST_LANE       = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first;
        logic [LEN_W-1:0]  block_len;
        logic [1:0]        addr_low;
    } item_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash_a;
        logic [HASH_W-1:0] sum_b;
    } sums_t;

    function automatic logic [HASH_W-1:0] rotr1(input logic [HASH_W-1:0] x);
        rotr1 = {x[0], x[HASH_W-1:1]};
    endfunction

endpackage
`default_nettype wire

[rtl/dsrbh_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsrbh_core
// Hash state and the combinational step that folds one byte into it.
// ----------------------------------------------------------------------------
module dsrbh_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dsrbh_pkg::item_t item,
    input  wire logic           advance,
    output logic                result_flag,
    output dsrbh_pkg::sums_t    sums
);
    import dsrbh_pkg::*;

    logic [HASH_W-1:0]    hash_a_reg, hash_a_next;
    logic [HASH_W-1:0]    sum_b_reg, sum_b_next;
    logic [LEN_W-1:0]     bytes_left_reg, bytes_left_next;
    logic [1:0]           align_left_reg, align_left_next;
    logic [PARTIAL_W-1:0] partial_word_reg, partial_word_next;
    logic [1:0]           byte_in_word_reg, byte_in_word_next;
    logic [1:0]           word_in_group_reg, word_in_group_next;
    logic                 grouped_mode_reg, grouped_mode_next;

    // State after a possible restart by the first byte
    logic [HASH_W-1:0]    a_l, b_l;
    logic [LEN_W-1:0]     left_l;
    logic [1:0]           align_l;
    logic [PARTIAL_W-1:0] pw_l;
    logic [1:0]           biw_l, wig_l;
    logic                 gm_l;
    logic                 empty_block;

    logic [HASH_W-1:0]    word;
    logic [HASH_W-1:0]    byte_ext;
    logic [HASH_W-1:0]    a_rot, b_sum;
    logic                 gm_eff;
    logic [1:0]           wig_inc;

    always_comb
    begin
        a_l         = hash_a_reg;
        b_l         = sum_b_reg;
        left_l      = bytes_left_reg;
        align_l     = align_left_reg;
        pw_l        = partial_word_reg;
        biw_l       = byte_in_word_reg;
        wig_l       = word_in_group_reg;
        gm_l        = grouped_mode_reg;
        empty_block = 1'b0;
        if (item.first)
        begin
            a_l    = '0;
            b_l    = '0;
            left_l = item.block_len;
            // bytes to reach the next word boundary
            align_l = 2'd0 - item.addr_low;
            pw_l   = '0;
            biw_l  = '0;
            wig_l  = '0;
            gm_l   = 1'b0;
            if (item.block_len == '0)
            begin
                align_l     = '0;
                empty_block = 1'b1;
            end
        end
    end

    always_comb
    begin
        byte_ext = {{(HASH_W-BYTE_W){1'b0}}, item.data_byte};
        word     = {item.data_byte, pw_l};
        gm_eff   = (biw_l == '0 && wig_l == '0) ? (left_l >= GROUP_MIN_BYTES) : gm_l;
        wig_inc  = wig_l + 2'd1;

        hash_a_next        = a_l;
        sum_b_next         = b_l;
        bytes_left_next    = left_l;
        align_left_next    = align_l;
        partial_word_next  = pw_l;
        byte_in_word_next  = biw_l;
        word_in_group_next = wig_l;
        grouped_mode_next  = gm_l;
        a_rot              = '0;
        b_sum              = '0;

        if (left_l != '0)
        begin
            bytes_left_next = left_l - 16'd1;
            if (align_l != '0)
            begin
                hash_a_next     = {a_l[HASH_W-BYTE_W-1:0], item.data_byte};
                align_left_next = align_l - 2'd1;
            end
            else if (biw_l == '0 && left_l < WORD_BYTES)
            begin
                hash_a_next = rotr1(a_l ^ byte_ext);
                sum_b_next  = b_l + byte_ext;
            end
            else
            begin
                grouped_mode_next = gm_eff;
                if (biw_l != LAST_LANE)
                begin
                    case (biw_l)
                        2'd0:    partial_word_next[7:0]   = item.data_byte;
                        2'd1:    partial_word_next[15:8]  = item.data_byte;
                        default: partial_word_next[23:16] = item.data_byte;
                    endcase
                    byte_in_word_next = biw_l + 2'd1;
                end
                else
                begin
                    a_rot             = rotr1(a_l ^ word);
                    b_sum             = b_l + word;
                    sum_b_next        = b_sum;
                    partial_word_next = '0;
                    byte_in_word_next = '0;
                    hash_a_next       = a_rot;
                    if (gm_eff)
                    begin
                        word_in_group_next = wig_inc;
                        // close the group of four
                        if (wig_inc == '0)
                        begin
                            hash_a_next = a_rot ^ b_sum;
                        end
                    end
                    else
                    begin
                        word_in_group_next = '0;
                        hash_a_next        = a_rot ^ b_sum;
                    end
                end
            end
        end
    end

    assign result_flag  = empty_block || (left_l == 16'd1);
    assign sums.hash_a  = hash_a_next;
    assign sums.sum_b   = sum_b_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_a_reg        <= '0;
            sum_b_reg         <= '0;
            bytes_left_reg    <= '0;
            align_left_reg    <= '0;
            partial_word_reg  <= '0;
            byte_in_word_reg  <= '0;
            word_in_group_reg <= '0;
            grouped_mode_reg  <= 1'b0;
        end
        else if (advance)
        begin
            hash_a_reg        <= hash_a_next;
            sum_b_reg         <= sum_b_next;
            bytes_left_reg    <= bytes_left_next;
            align_left_reg    <= align_left_next;
            partial_word_reg  <= partial_word_next;
            byte_in_word_reg  <= byte_in_word_next;
            word_in_group_reg <= word_in_group_next;
            grouped_mode_reg  <= grouped_mode_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A result always ends the block
    a_result_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result_flag) |=> (bytes_left_reg == '0))
        else $error("block still open after its result");

    // Word gathering never starts before alignment is done
    a_align_no_gather: assert property (@(posedge clk) disable iff (!rst_n)
        (align_left_reg != '0) |-> (byte_in_word_reg == '0))
        else $error("bytes gathered while still aligning");

    // Partial word is clear whenever no byte is gathered
    a_partial_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_in_word_reg == '0) |-> (partial_word_reg == '0))
        else $error("stale partial word");
`endif

endmodule
`default_nettype wire

[rtl/dsrbh_out.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsrbh_out
// Result stage holding the final sums and output register holding A + B.
// ----------------------------------------------------------------------------
module dsrbh_out (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire dsrbh_pkg::sums_t sums,
    output logic                  res_free,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [dsrbh_pkg::HASH_W-1:0] hash
);
    import dsrbh_pkg::*;

    logic              res_valid_reg, res_valid_next;
    sums_t             res_sums_reg;
    logic              out_valid_reg, out_valid_next;
    logic [HASH_W-1:0] hash_reg;
    logic              res_adv;

    // Move the sums on when the output register is empty or being taken
    assign res_adv        = res_valid_reg && (!out_valid_reg || !out_stall);
    assign res_free       = !res_valid_reg || res_adv;
    assign res_valid_next = load || (res_valid_reg && !res_adv);
    assign out_valid_next = res_adv || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_sums_reg <= sums;
        end
        if (res_adv)
        begin
            hash_reg <= res_sums_reg.hash_a + res_sums_reg.sum_b;
        end
    end

    assign out_valid = out_valid_reg;
    assign hash      = hash_reg;

`ifndef NO_ASSERTIONS
    // Never overwrite a result that has not moved on
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> res_free)
        else $error("result stage overwritten");

    // A blocked result stays put
    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && out_valid_reg && out_stall) |=> res_valid_reg)
        else $error("blocked result dropped");
`endif

endmodule
`default_nettype wire

[rtl/dual_sum_rotate_block_hash.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dual_sum_rotate_block_hash
// Dual-sum rotating hash over a block of code bytes, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one byte per item. The item
//   with first set restarts the hash and supplies block_len and addr_low;
//   later items of the block only need data_byte.
//   Output channel (out_valid / out_stall) carries one hash per block, after
//   the block's last byte (or at once for a zero-length block).
//   Throughput: one item per cycle while in_stall is low, set by the
//   combinational rotate/XOR/add step between the input and state registers.
//   Path: the block's last byte is accepted into the input register; its
//   sums pass through the state step into the result stage, then the
//   output register that forms A + B shows the hash on the output port.
//   Stalls: the result and output registers hold finished hashes while the
//   receiver stalls; bytes that produce no hash keep flowing until a third
//   pending hash would have nowhere to go, then in_stall rises.
//   Reset: clears all hash state and empties every stage; items with first
//   low and no open block are dropped without a result.
// ----------------------------------------------------------------------------
module dual_sum_rotate_block_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first,
    input  wire logic [15:0] block_len,
    input  wire logic [1:0]  addr_low,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      hash
);
    import dsrbh_pkg::*;

    logic  s1_valid_reg, s1_valid_next;
    item_t s1_item_reg;
    logic  s1_load, s1_adv;
    logic  result_flag, res_free;
    sums_t sums;

    // A byte that yields no hash never waits on the output side
    assign s1_adv        = s1_valid_reg && (!result_flag || res_free);
    assign in_stall      = s1_valid_reg && !s1_adv;
    assign s1_load       = in_valid && !in_stall;
    assign s1_valid_next = s1_load || (s1_valid_reg && !s1_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_item_reg.data_byte <= data_byte;
            s1_item_reg.first     <= first;
            s1_item_reg.block_len <= block_len;
            s1_item_reg.addr_low  <= addr_low;
        end
    end

    dsrbh_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (s1_item_reg),
        .advance     (s1_adv),
        .result_flag (result_flag),
        .sums        (sums)
    );

    dsrbh_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_adv && result_flag),
        .sums      (sums),
        .res_free  (res_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hash      (hash)
    );

endmodule
`default_nettype wire
